// ===== hdl/cdn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cdn_pkg
// Constants and month tables for the calendar date to day number pipeline.
// ----------------------------------------------------------------------------
package cdn_pkg;

	localparam int YearW   = 19;
	localparam int MonthW  = 4;
	localparam int DayW    = 5;
	localparam int DaysW   = 27;
	localparam int WdayW   = 3;
	localparam int MonthsW = 22;

	// Largest year that is accepted as valid.
	localparam logic [YearW-1:0] YearLimit = 19'd292451;

	// Last Julian date is 1752-09-02, first Gregorian date is 1752-09-14.
	localparam logic [YearW-1:0]  SwitchYear     = 19'd1752;
	localparam logic [MonthW-1:0] SwitchMonth    = 4'd9;
	localparam logic [DayW-1:0]   LastJulianDay  = 5'd2;
	localparam logic [DayW-1:0]   FirstGregDay   = 5'd14;

	// From 1800-03-01 on the century correction includes the current century.
	localparam logic [YearW-1:0]  CenturyYear    = 19'd1800;
	localparam logic [MonthW-1:0] CenturyMonth   = 4'd3;

	localparam logic [MonthW-1:0] MonthFeb       = 4'd2;
	localparam logic [MonthW-1:0] MonthMar       = 4'd3;
	localparam logic [MonthW-1:0] MonthDec       = 4'd12;
	localparam logic [DayW-1:0]   FebLeapDays    = 5'd29;

	localparam logic [8:0] DaysPerYear = 9'd365;

	// Reciprocals for division by a constant: q = (x * Recip) >> Shift.
	localparam int             Div100Shift = 26;
	localparam logic [19:0]    Div100Recip = 20'd671089;
	localparam int             Div7Shift   = 30;
	localparam logic [27:0]    Div7Recip   = 28'd153391690;

	// Length of a month outside a leap February; zero for codes that are no month.
	function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] mo);
		logic [DayW-1:0] len;
		case (mo)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the months before the given one, February taken as 28 days.
	function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] mo);
		logic [8:0] cum;
		case (mo)
			4'd1:    cum = 9'd0;
			4'd2:    cum = 9'd31;
			4'd3:    cum = 9'd59;
			4'd4:    cum = 9'd90;
			4'd5:    cum = 9'd120;
			4'd6:    cum = 9'd151;
			4'd7:    cum = 9'd181;
			4'd8:    cum = 9'd212;
			4'd9:    cum = 9'd243;
			4'd10:   cum = 9'd273;
			4'd11:   cum = 9'd304;
			4'd12:   cum = 9'd334;
			default: cum = 9'd0;
		endcase
		return cum;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/calendar_date_to_day_number_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_to_day_number_top
// Converts a BC/AD date into a validity flag, a day count, a weekday and a
// month count, using Julian rules up to 1752-09-02 and Gregorian rules after.
// ----------------------------------------------------------------------------
// The block is a five-stage pipeline that takes one date in every cycle while
// req_ready is high; a date passes through the five stage registers (date
// decode with a divide by 100, leap and validity check, day and month sums,
// divide by 7, weekday) in that order. A stall on the result side holds
// every full stage and lets bubbles close up, so req_ready drops only when
// all five stages hold an item. Invalid dates give zero in every count field.
// ----------------------------------------------------------------------------
module calendar_date_to_day_number_top
	import cdn_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic                 is_bc,
	input  wire logic [YearW-1:0]     year_number,
	input  wire logic [MonthW-1:0]    month_number,
	input  wire logic [DayW-1:0]      day_of_month,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output logic                      date_valid,
	output logic [DaysW-1:0]          elapsed_days,
	output logic [WdayW-1:0]          weekday,
	output logic [MonthsW-1:0]        elapsed_months
);

	// Handshake and stage valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5      = !v_s5 || res_ready;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign req_ready = rdy1;
	assign res_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: range checks, switch-date compares, year / 100.
	// ------------------------------------------------------------------
	logic [38:0]       prod100;
	logic              after_low, before_high, ge_century, basic_ok;

	assign prod100 = 39'(year_number) * 39'(Div100Recip);

	always_comb begin
		after_low = (year_number > SwitchYear) ||
			((year_number == SwitchYear) && ((month_number > SwitchMonth) ||
			((month_number == SwitchMonth) && (day_of_month > LastJulianDay))));
		before_high = (year_number < SwitchYear) ||
			((year_number == SwitchYear) && ((month_number < SwitchMonth) ||
			((month_number == SwitchMonth) && (day_of_month < FirstGregDay))));
		ge_century = (year_number > CenturyYear) ||
			((year_number == CenturyYear) && (month_number >= CenturyMonth));
		basic_ok = (month_number != '0) && (month_number <= MonthDec) &&
			(year_number != '0) && (year_number <= YearLimit) &&
			(day_of_month != '0) && !(!is_bc && after_low && before_high);
	end

	logic                 bc_s1, after_s1, ge_cent_s1, ok_s1;
	logic [YearW-1:0]     y_s1;
	logic [MonthW-1:0]    mo_s1;
	logic [DayW-1:0]      d_s1;
	logic [12:0]          q100_s1;
	logic [DayW-1:0]      mlen_s1;
	logic [8:0]           cum_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			bc_s1      <= is_bc;
			y_s1       <= year_number;
			mo_s1      <= month_number;
			d_s1       <= day_of_month;
			after_s1   <= after_low;
			ge_cent_s1 <= ge_century;
			ok_s1      <= basic_ok;
			q100_s1    <= prod100[Div100Shift +: 13];
			mlen_s1    <= month_length(month_number);
			cum_s1     <= days_before_month(month_number);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: leap rule, validity, year term and the partial day sum.
	// ------------------------------------------------------------------
	logic [YearW-1:0] r100, ym1;
	logic [1:0]       y4;
	logic             cent_year, quad_cent, early, leap, valid2, kterm, cond1;
	logic [9:0]       doy, doy_dir;
	logic [19:0]      yp2;
	logic [17:0]      leapcnt;
	logic             leap_extra;
	logic [14:0]      sub_c, corr;
	logic [27:0]      yr365;
	logic [19:0]      part;

	always_comb begin
		r100      = y_s1 - YearW'(q100_s1) * 19'd100;
		cent_year = (r100 == '0);
		quad_cent = cent_year && (q100_s1[1:0] == 2'd0);
		ym1       = y_s1 - 19'd1;
		early     = (mo_s1 < MonthMar);

		// For BC years the Julian leap year is the one after a multiple of four.
		y4 = bc_s1 ? ym1[1:0] : y_s1[1:0];
		if (!after_s1 || bc_s1) begin
			leap = (y4 == 2'd0);
		end else begin
			leap = (y_s1[1:0] == 2'd0) && (!cent_year || quad_cent);
		end

		if (mo_s1 == MonthFeb) begin
			valid2 = ok_s1 && (d_s1 <= FebLeapDays) && (leap || (d_s1 < FebLeapDays));
		end else begin
			valid2 = ok_s1 && (d_s1 <= mlen_s1);
		end

		doy     = 10'(cum_s1) + 10'(d_s1) - 10'd1;
		doy_dir = bc_s1 ? (10'(DaysPerYear) - doy) : doy;
		yr365   = 28'(ym1) * 28'(DaysPerYear);

		yp2 = {1'b0, y_s1} + 20'd2;
		if (bc_s1) begin
			leapcnt    = yp2[19:2];
			leap_extra = early && (y_s1[1:0] == 2'd1);
		end else begin
			leapcnt    = {1'b0, ym1[18:2]};
			leap_extra = !early && (y_s1[1:0] == 2'd0);
		end

		// Gregorian correction after the switch: ten-plus-one lost days, the
		// centuries skipped so far, and the four-century years put back.
		cond1 = early && cent_year;
		kterm = !(quad_cent && early);
		if (cond1) begin
			sub_c = 15'(q100_s1) - 15'd18;
		end else if (ge_cent_s1) begin
			sub_c = 15'(q100_s1) - 15'd17;
		end else begin
			sub_c = '0;
		end
		if (!bc_s1 && after_s1) begin
			corr = 15'(q100_s1[12:2]) + 15'(kterm) - 15'd16 - sub_c;
		end else begin
			corr = '0;
		end

		part = 20'(doy_dir) + 20'(leapcnt) + 20'(leap_extra) + {{5{corr[14]}}, corr};
	end

	logic              bc_s2, valid_s2;
	logic [YearW-1:0]  ym1_s2;
	logic [MonthW-1:0] mo_s2;
	logic [27:0]       yr365_s2;
	logic [19:0]       part_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			bc_s2    <= bc_s1;
			valid_s2 <= valid2;
			ym1_s2   <= ym1;
			mo_s2    <= mo_s1;
			yr365_s2 <= yr365;
			part_s2  <= part;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: day count and month count, cleared for invalid dates.
	// ------------------------------------------------------------------
	logic [DaysW-1:0]   days3;
	logic [MonthsW-1:0] months3;
	logic [MonthW-1:0]  mpos;

	always_comb begin
		days3   = yr365_s2[DaysW-1:0] + {{(DaysW-20){part_s2[19]}}, part_s2};
		mpos    = bc_s2 ? (MonthDec + 4'd1 - mo_s2) : (mo_s2 - 4'd1);
		months3 = MonthsW'({ym1_s2, 3'b000}) + MonthsW'({ym1_s2, 2'b00}) + MonthsW'(mpos);
	end

	logic               bc_s3, valid_s3;
	logic [DaysW-1:0]   days_s3;
	logic [MonthsW-1:0] months_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			bc_s3     <= bc_s2;
			valid_s3  <= valid_s2;
			days_s3   <= valid_s2 ? days3 : '0;
			months_s3 <= valid_s2 ? months3 : '0;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: day count / 7.
	// ------------------------------------------------------------------
	logic [54:0] prod7;

	assign prod7 = 55'(days_s3) * 55'(Div7Recip);

	logic               bc_s4, valid_s4;
	logic [DaysW-1:0]   days_s4;
	logic [MonthsW-1:0] months_s4;
	logic [24:0]        q7_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			bc_s4     <= bc_s3;
			valid_s4  <= valid_s3;
			days_s4   <= days_s3;
			months_s4 <= months_s3;
			q7_s4     <= prod7[Div7Shift +: 25];
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: weekday, which runs backward for BC dates.
	// ------------------------------------------------------------------
	logic [WdayW-1:0] r7, wd;

	always_comb begin
		r7 = WdayW'(days_s4 - DaysW'(q7_s4) * DaysW'(7));
		if (bc_s4 && (r7 != '0)) begin
			wd = 3'd7 - r7;
		end else begin
			wd = r7;
		end
	end

	logic               valid_s5;
	logic [DaysW-1:0]   days_s5;
	logic [WdayW-1:0]   wd_s5;
	logic [MonthsW-1:0] months_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			valid_s5  <= valid_s4;
			days_s5   <= days_s4;
			wd_s5     <= wd;
			months_s5 <= months_s4;
		end
	end

	assign date_valid     = valid_s5;
	assign elapsed_days   = days_s5;
	assign weekday        = wd_s5;
	assign elapsed_months = months_s5;

endmodule
`default_nettype wire
